// ===== rtl/pidca_pkg.sv =====
// shared types, widths, register indexes and reset values for the clamped pid block
package pidca_pkg;

  // field widths fixed by the angle and gain formats
  localparam int ANGLE_W = 9;
  localparam int GAIN_W  = 24;
  localparam int ERR_W   = 11;
  localparam int DIFF_W  = 12;
  localparam int IDX_W   = 3;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_KP       = 3'd0,
    REG_KI       = 3'd1,
    REG_KD       = 3'd2,
    REG_SETPOINT = 3'd3,
    REG_OUT_MIN  = 3'd4,
    REG_OUT_MAX  = 3'd5
  } reg_idx_t;

  // reset values of the configuration registers
  localparam logic [GAIN_W-1:0]         KP_RESET       = 24'd131072;
  localparam logic [GAIN_W-1:0]         KI_RESET       = 24'd655;
  localparam logic [GAIN_W-1:0]         KD_RESET       = 24'd655360;
  localparam logic signed [ANGLE_W-1:0] SETPOINT_RESET = 9'sd0;
  localparam logic signed [ANGLE_W-1:0] OUT_MIN_RESET  = -9'sd45;
  localparam logic signed [ANGLE_W-1:0] OUT_MAX_RESET  = 9'sd45;

  // gains, target and output limits
  typedef struct packed {
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [GAIN_W-1:0]         kd;
    logic signed [ANGLE_W-1:0] setpoint;
    logic signed [ANGLE_W-1:0] out_min;
    logic signed [ANGLE_W-1:0] out_max;
  } cfg_t;

  // limit and integration status of one sample
  typedef struct packed {
    logic hit_hi;
    logic hit_lo;
    logic hold;
  } law_stat_t;

endpackage

// ===== rtl/pidca_law.sv =====
// control law: error, p/i/d terms, output clamp and conditional integration
module pidca_law
  import pidca_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 16,
  parameter int SUM_BITS       = 32
) (
  input  cfg_t                       cfg,
  input  logic signed [ANGLE_W-1:0]  meas,
  input  logic signed [SUM_BITS-1:0] error_sum,
  input  logic signed [ERR_W-1:0]    last_error,
  output logic signed [ERR_W-1:0]    err,
  output logic signed [SUM_BITS-1:0] error_sum_next,
  output logic signed [ANGLE_W-1:0]  drive,
  output law_stat_t                  stat
);

  localparam int P_W = ERR_W + GAIN_W + 1;
  localparam int D_W = DIFF_W + GAIN_W + 1;
  localparam int I_W = SUM_BITS + GAIN_W + 1;
  localparam int U_W = SUM_BITS + GAIN_W + 3;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [P_W-1:0]      p_term;
  logic signed [I_W-1:0]      i_term;
  logic signed [D_W-1:0]      d_term;
  logic signed [U_W-1:0]      u;
  logic signed [U_W-1:0]      lo;
  logic signed [U_W-1:0]      hi;
  logic signed [SUM_BITS:0]   sum_wide;
  logic signed [SUM_BITS-1:0] sum_sat;
  logic [ANGLE_W-1:0]         q_floor;
  logic [ANGLE_W-1:0]         q_trunc;
  logic                       frac_nz;
  logic                       err_le0;
  logic                       err_ge0;

  // error and its change since the previous sample
  assign err  = ERR_W'(cfg.setpoint) - ERR_W'(meas);
  assign diff = DIFF_W'(err) - DIFF_W'(last_error);

  // three gain products, full width so no term can wrap
  assign p_term = P_W'(err) * $signed({1'b0, cfg.kp});
  assign i_term = I_W'(error_sum) * $signed({1'b0, cfg.ki});
  assign d_term = D_W'(diff) * $signed({1'b0, cfg.kd});
  assign u      = U_W'(p_term) + U_W'(i_term) + U_W'(d_term);

  // limits scaled to the gain fraction
  assign lo = U_W'(cfg.out_min) <<< GAIN_FRAC_BITS;
  assign hi = U_W'(cfg.out_max) <<< GAIN_FRAC_BITS;

  assign stat.hit_hi = (u >= hi);
  assign stat.hit_lo = (u <= lo);

  // hold the integral while the output pushes further into a limit
  assign err_le0   = err[ERR_W-1] || (err == '0);
  assign err_ge0   = !err[ERR_W-1];
  assign stat.hold = (stat.hit_lo && err_le0) || (stat.hit_hi && err_ge0);

  // saturating integral update
  assign sum_wide = (SUM_BITS+1)'(error_sum) + (SUM_BITS+1)'(err);
  always_comb begin
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_sat = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                   : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_BITS-1:0];
    end
  end
  assign error_sum_next = stat.hold ? error_sum : sum_sat;

  // truncate toward zero: floor, plus one for a negative value with a fraction
  assign q_floor = u[GAIN_FRAC_BITS +: ANGLE_W];
  assign frac_nz = |u[GAIN_FRAC_BITS-1:0];
  assign q_trunc = q_floor + ANGLE_W'(u[U_W-1] && frac_nz);

  // output clamp, upper limit tested first
  always_comb begin
    if (stat.hit_hi) begin
      drive = cfg.out_max;
    end else if (stat.hit_lo) begin
      drive = cfg.out_min;
    end else begin
      drive = $signed(q_trunc);
    end
  end

endmodule

// ===== rtl/pid_clamped_antiwindup.sv =====
// top level of the clamped pid angle controller with conditional integration
// One measured angle in, one clamped drive angle out, one word per clock cycle
// sustained while out_ready stays high. A word is captured in an input
// register, then the whole control law (three gain multiplies, the sum, the
// limit compares and the integral update) runs as one combinational pass into
// the result register, so that single pass sets the clock rate. While a result
// waits, the input side takes a word only if the input register is empty.
// Gains carry GAIN_FRAC_BITS fraction bits; the error integral is SUM_BITS
// wide and saturates. Configuration writes are taken at any time and are meant
// to be made while no word is in flight.
module pid_clamped_antiwindup
  import pidca_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 16,
  parameter int SUM_BITS       = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [GAIN_W-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] measured_angle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ANGLE_W-1:0] drive_angle
);

  cfg_t                       cfg;
  logic                       meas_valid;
  logic signed [ANGLE_W-1:0]  meas;
  logic signed [SUM_BITS-1:0] error_sum;
  logic signed [ERR_W-1:0]    last_error;
  logic signed [ERR_W-1:0]    err_next;
  logic signed [SUM_BITS-1:0] error_sum_next;
  logic signed [ANGLE_W-1:0]  drive_next;
  law_stat_t                  stat;
  logic                       out_free;
  logic                       advance;

  // handshake control
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign advance   = meas_valid && out_free;
  assign in_ready  = !meas_valid || out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp       <= KP_RESET;
      cfg.ki       <= KI_RESET;
      cfg.kd       <= KD_RESET;
      cfg.setpoint <= SETPOINT_RESET;
      cfg.out_min  <= OUT_MIN_RESET;
      cfg.out_max  <= OUT_MAX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KP:       cfg.kp       <= cfg_data;
        REG_KI:       cfg.ki       <= cfg_data;
        REG_KD:       cfg.kd       <= cfg_data;
        REG_SETPOINT: cfg.setpoint <= $signed(cfg_data[ANGLE_W-1:0]);
        REG_OUT_MIN:  cfg.out_min  <= $signed(cfg_data[ANGLE_W-1:0]);
        REG_OUT_MAX:  cfg.out_max  <= $signed(cfg_data[ANGLE_W-1:0]);
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      meas_valid <= 1'b0;
    end else if (in_ready) begin
      meas_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meas <= measured_angle;
    end
  end

  pidca_law #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .SUM_BITS       (SUM_BITS)
  ) u_law (
    .cfg            (cfg),
    .meas           (meas),
    .error_sum      (error_sum),
    .last_error     (last_error),
    .err            (err_next),
    .error_sum_next (error_sum_next),
    .drive          (drive_next),
    .stat           (stat)
  );

  // controller state, updated once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (advance) begin
      error_sum  <= error_sum_next;
      last_error <= err_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= meas_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_angle <= drive_next;
    end
  end

`ifndef SYNTH
  // state moves only when a word passes into the result register
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(error_sum) && $stable(last_error))
    else $error("controller state changed without a word advancing");

  // integral frozen while the output drives into a limit
  assert property (@(posedge clk) disable iff (rst)
    advance && stat.hold |=> $stable(error_sum))
    else $error("integral changed while held at a limit");

  // a captured word is not dropped while the result register is blocked
  assert property (@(posedge clk) disable iff (rst)
    meas_valid && !out_free |=> meas_valid && $stable(meas))
    else $error("input word lost while output stalled");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the clamped pid angle controller with conditional integration
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pidca_pkg::*;

  localparam int     GAIN_FRAC   = 16;
  localparam int     SUM_W       = 32;
  localparam longint UNITY       = longint'(1) << GAIN_FRAC;
  localparam longint SUM_MAX     = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_MIN     = -SUM_MAX - 1;
  localparam int     NPHASE      = 9;
  localparam int     PHASE_ITEMS = 50;
  localparam int     SETTLE      = 4;
  localparam int     LONG_HOLD   = 48;
  localparam int     WATCHDOG    = 2000;
  localparam int     PLAN_ROWS   = 41;

  // register indexes the block has no register behind
  localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // one line of the directed plan: a register write or a sample word
  typedef struct packed {
    row_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [GAIN_W-1:0]  data;
    angle_t             angle;
    logic               typed;
    angle_t             want;
  } plan_row_t;

  localparam plan_row_t DIRECTED [PLAN_ROWS] = '{
    // reset gains: 2.0, about 0.01, 10.0 with limits of +-45
    '{ROW_SAMPLE, '0, '0, 9'sd0,     1'b1, 9'sd0},
    '{ROW_SAMPLE, '0, '0, -9'sd180,  1'b1, 9'sd45},
    '{ROW_SAMPLE, '0, '0, 9'sd180,   1'b1, -9'sd45},
    '{ROW_SAMPLE, '0, '0, 9'sd0,     1'b1, 9'sd45},
    '{ROW_SAMPLE, '0, '0, 9'sd0,     1'b1, 9'sd0},
    '{ROW_SAMPLE, '0, '0, 9'h0FF,    1'b1, -9'sd45},
    '{ROW_SAMPLE, '0, '0, 9'h100,    1'b1, 9'sd45},
    '{ROW_SAMPLE, '0, '0, 9'sd3,     1'b0, '0},
    '{ROW_SAMPLE, '0, '0, -9'sd7,    1'b0, '0},
    // zero gains with swapped limits: the upper test wins
    '{ROW_WRITE, REG_KP,      24'd0,       '0, 1'b0, '0},
    '{ROW_WRITE, REG_KI,      24'd0,       '0, 1'b0, '0},
    '{ROW_WRITE, REG_KD,      24'd0,       '0, 1'b0, '0},
    '{ROW_WRITE, REG_OUT_MIN, 24'd10,      '0, 1'b0, '0},
    '{ROW_WRITE, REG_OUT_MAX, 24'h0001F6,  '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 9'sd20,    1'b1, -9'sd10},
    '{ROW_SAMPLE, '0, '0, -9'sd20,   1'b1, -9'sd10},
    // full-scale gains and limits, junk above the angle bits
    '{ROW_WRITE, REG_OUT_MIN,  24'h000100, '0, 1'b0, '0},
    '{ROW_WRITE, REG_OUT_MAX,  24'h0000FF, '0, 1'b0, '0},
    '{ROW_WRITE, REG_SETPOINT, 24'hFFFF00, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KP,       24'hFFFFFF, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KI,       24'hFFFFFF, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KD,       24'hFFFFFF, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 9'h0FF,    1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 9'h100,    1'b0, '0},
    '{ROW_WRITE, REG_SETPOINT, 24'h0000FF, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 9'h100,    1'b0, '0},
    // writes to spare indexes must change nothing
    '{ROW_WRITE, IDX_SPARE_LO, 24'hFFFFFF, '0, 1'b0, '0},
    '{ROW_WRITE, IDX_SPARE_HI, 24'h000000, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 9'sd0,     1'b0, '0},
    // unity proportional gain only, limits +-180
    '{ROW_WRITE, REG_KP,       24'h010000, '0, 1'b0, '0},
    '{ROW_WRITE, REG_KI,       24'd0,      '0, 1'b0, '0},
    '{ROW_WRITE, REG_KD,       24'd0,      '0, 1'b0, '0},
    '{ROW_WRITE, REG_SETPOINT, 24'd0,      '0, 1'b0, '0},
    '{ROW_WRITE, REG_OUT_MIN,  24'h00014C, '0, 1'b0, '0},
    '{ROW_WRITE, REG_OUT_MAX,  24'd180,    '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 9'sd100,   1'b1, -9'sd100},
    '{ROW_SAMPLE, '0, '0, -9'sd180,  1'b1, 9'sd180},
    '{ROW_SAMPLE, '0, '0, 9'sd179,   1'b1, -9'sd179},
    // gain 1.5: fractions truncate toward zero on both signs
    '{ROW_WRITE, REG_KP,       24'h018000, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 9'sd3,     1'b1, -9'sd4},
    '{ROW_SAMPLE, '0, '0, -9'sd3,    1'b1, 9'sd4}
  };

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index      = '0;
  logic [GAIN_W-1:0]   cfg_data       = '0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  angle_t              measured_angle = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  angle_t              drive_angle;

  // controller copy: settings, error integral, previous error
  cfg_t   ctl;
  longint integ;
  longint prev_err;
  angle_t pending_drive [$];

  bit src_idle_on  = 1'b0;
  bit sink_idle_on = 1'b0;
  bit hold_req     = 1'b0;
  int sink_wait    = 0;
  int quiet        = 0;
  int faults       = 0;
  int samples_sent = 0;
  int drives_seen  = 0;
  int settings     = 0;

  pid_clamped_antiwindup #(
    .GAIN_FRAC_BITS(GAIN_FRAC),
    .SUM_BITS      (SUM_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .measured_angle(measured_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_angle   (drive_angle)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one step of the control law; the three products stay far below the
  // 2^63 limit of a longint, so plain 64-bit arithmetic is exact
  function automatic angle_t control_law(input angle_t meas);
    longint e, u, lo, hi, mag;
    angle_t drv;
    e  = longint'($signed(ctl.setpoint)) - longint'(meas);
    u  = e * longint'(ctl.kp) + integ * longint'(ctl.ki)
       + (e - prev_err) * longint'(ctl.kd);
    lo = longint'($signed(ctl.out_min)) * UNITY;
    hi = longint'($signed(ctl.out_max)) * UNITY;
    // integrate unless the error drives further into a limit already hit
    if (!((u <= lo && e <= 0) || (u >= hi && e >= 0))) begin
      integ = integ + e;
      if (integ > SUM_MAX) integ = SUM_MAX;
      else if (integ < SUM_MIN) integ = SUM_MIN;
    end
    prev_err = e;
    if (u >= hi) begin
      drv = ctl.out_max;
    end else if (u <= lo) begin
      drv = ctl.out_min;
    end else begin
      mag = (u < 0) ? -u : u;
      mag = mag >> GAIN_FRAC;
      drv = angle_t'((u < 0) ? -mag : mag);
    end
    return drv;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain(input int typical_max);
    logic [GAIN_W-1:0] g;
    case ($urandom_range(0, 9))
      0:       g = '0;
      1:       g = '1;
      default: g = GAIN_W'($urandom_range(0, typical_max));
    endcase
    return g;
  endfunction

  // angle in the low bits, sometimes junk above them
  function automatic logic [GAIN_W-1:0] angle_word(input int v);
    logic [GAIN_W-1:0] w;
    w = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom) : '0;
    w[ANGLE_W-1:0] = angle_t'(v);
    return w;
  endfunction

  task automatic report_fault(input string what, input angle_t want, input angle_t got);
    faults++;
    if (faults <= 10)
      $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KP:       ctl.kp       = data;
      REG_KI:       ctl.ki       = data;
      REG_KD:       ctl.kd       = data;
      REG_SETPOINT: ctl.setpoint = data[ANGLE_W-1:0];
      REG_OUT_MIN:  ctl.out_min  = data[ANGLE_W-1:0];
      REG_OUT_MAX:  ctl.out_max  = data[ANGLE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one sample word, with an optional gap in front of it
  task automatic offer_angle(input angle_t a, input logic typed, input angle_t want);
    angle_t predicted;
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    measured_angle <= a;
    do @(posedge clk); while (!in_ready);
    predicted = control_law(a);
    pending_drive.push_back(typed ? want : predicted);
    samples_sent++;
  endtask

  // stop offering and let every drive word come out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // random gains, target and limits for one phase
  task automatic pick_setting();
    int lo, hi, tmp;
    lo = $urandom_range(0, 180) - 180;
    hi = $urandom_range(0, 180);
    case ($urandom_range(0, 7))
      0: begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      1: begin
        lo = -256;
        hi = 255;
      end
      default: ;
    endcase
    write_reg(REG_KP, pick_gain(4 << GAIN_FRAC));
    write_reg(REG_KI, pick_gain(2048));
    write_reg(REG_KD, pick_gain(8 << GAIN_FRAC));
    write_reg(REG_SETPOINT, angle_word($urandom_range(0, 180) - 90));
    write_reg(REG_OUT_MIN, angle_word(lo));
    write_reg(REG_OUT_MAX, angle_word(hi));
    settings++;
  endtask

  // receiver: random stall bursts, plus one long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      sink_wait = LONG_HOLD;
    end else if (sink_wait == 0 && sink_idle_on && $urandom_range(0, 7) == 0) begin
      sink_wait = $urandom_range(1, 16);
    end
    if (sink_wait > 0) begin
      out_ready <= 1'b0;
      sink_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // drive word check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (out_valid && out_ready) begin
        drives_seen++;
        if (pending_drive.size() == 0)
          report_fault("drive word with none pending", 'x, drive_angle);
        else if (drive_angle !== pending_drive[0])
          report_fault("drive_angle mismatch", pending_drive.pop_front(), drive_angle);
        else
          void'(pending_drive.pop_front());
      end
      if (quiet >= WATCHDOG) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int     walk_pos;
    bit     walk_mode;
    angle_t a;
    ctl      = '{KP_RESET, KI_RESET, KD_RESET, SETPOINT_RESET, OUT_MIN_RESET, OUT_MAX_RESET};
    integ    = 0;
    prev_err = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed plan with light idling on both sides
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    settings     = 1;
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        settle();
        write_reg(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        offer_angle(DIRECTED[r].angle, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end
    settings += 3;

    // random phases, each under its own setting
    for (int p = 0; p < NPHASE; p++) begin
      settle();
      pick_setting();
      src_idle_on  = (p < NPHASE - 1) && ($urandom_range(0, 2) != 0);
      sink_idle_on = (p < NPHASE - 1) && ($urandom_range(0, 2) != 0);
      // back-pressure phase: sender keeps going while the receiver holds off
      if (p == 1) begin
        src_idle_on = 1'b0;
        hold_req    = 1'b1;
      end
      walk_mode = $urandom_range(0, 1);
      walk_pos  = $urandom_range(0, 360) - 180;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          a = angle_t'($urandom);
        end else if (walk_mode) begin
          walk_pos += $urandom_range(0, 16) - 8;
          if (walk_pos > 180) walk_pos = 180;
          if (walk_pos < -180) walk_pos = -180;
          a = angle_t'(walk_pos);
        end else begin
          a = angle_t'($urandom_range(0, 360) - 180);
        end
        offer_angle(a, 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("%0d samples sent, %0d drive words checked, over %0d controller settings",
             samples_sent, drives_seen, settings);
    $display("settings included zero and full-scale gains, swapped limits and spare indexes");
    if (faults == 0 && pending_drive.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
